// ===== src/irfc_pkg.sv =====
// Shared types, constants and helpers for the infrared reply frame checker.
package irfc_pkg;

    // Payload store geometry
    localparam int STORE_DEPTH  = 64;
    localparam int STORE_AW     = 6;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_PAYLOAD = 63;
    localparam int DEF_MAX_FRAME   = 4096;

    // Configuration register indexes
    localparam logic [0:0] REG_COMP_MODE = 1'b0;
    localparam logic [0:0] REG_MAX_LEN   = 1'b1;

    // Reset value of the payload limit register
    localparam logic [5:0] MAX_LEN_RESET = 6'd32;

    // Reply status codes
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_BAD   = 2'd2
    } t_status;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_READ,
        S_SHOW,
        S_STATUS
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic take_byte;    // absorb the byte of the current input transfer
        logic do_check;     // evaluate the reply and clear the frame state
        logic read_req;     // issue a store read for the current payload index
        logic advance;      // step to the next payload index
        logic show_status;  // output carries the status item
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic emit_done;    // all accepted payload bytes have been transferred
    } t_dp_sts;

    // Expected header byte at a given position
    function automatic logic [7:0] hdr_byte(input logic [1:0] pos);
        logic [7:0] b;
        case (pos)
            2'd0:    b = 8'h55;
            2'd1:    b = 8'hff;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== src/irfc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module irfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/irfc_dp.sv =====
// Datapath: frame registers, reply checks, payload store and output fields.
module irfc_dp #(
    parameter int MAX_PAYLOAD = irfc_pkg::DEF_MAX_PAYLOAD,
    parameter int MAX_FRAME   = irfc_pkg::DEF_MAX_FRAME
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [0:0]          i_cfg_index,
    input  logic [5:0]          i_cfg_wdata,
    input  logic [7:0]          i_rx_byte,
    input  irfc_pkg::t_dp_cmd   i_cmd,
    output irfc_pkg::t_dp_sts   o_sts,
    output logic [7:0]          o_payload_byte,
    output logic                o_is_status,
    output logic [1:0]          o_status,
    output logic [5:0]          o_payload_length,
    output logic                o_last
);

    localparam int CNT_W = $clog2(MAX_FRAME + 1);
    localparam int OFF_W = (CNT_W > 7) ? CNT_W : 7;

    // Configuration
    logic                     r_comp_mode;
    logic [5:0]               r_max_len;

    // Frame state
    logic [CNT_W-1:0]         r_byte_count, n_byte_count;
    logic                     r_header_bad, n_header_bad;
    logic                     r_pair_bad,   n_pair_bad;
    logic [7:0]               r_sum,        n_sum;
    logic [7:0]               r_prev,       n_prev;
    logic [7:0]               r_newest,     n_newest;
    logic [7:0]               r_byte_four,  n_byte_four;
    logic [7:0]               r_byte_three, n_byte_three;

    // Check result and emission index
    irfc_pkg::t_status        r_stat,   n_stat;
    logic [5:0]               r_cnt,    n_cnt;
    logic                     r_layout, n_layout;
    logic [5:0]               r_k;

    // Store port signals
    logic                     st_we;
    logic [irfc_pkg::STORE_AW-1:0] st_waddr;
    logic [irfc_pkg::STORE_AW-1:0] st_raddr;
    logic [7:0]               st_rdata;

    // Byte intake helpers
    logic                     in_frame;
    logic [OFF_W-1:0]         off_w;
    logic [OFF_W-1:0]         half_w;
    logic                     fits;

    // Check helpers
    logic [OFF_W-1:0]         n_w;
    logic [OFF_W-1:0]         n_minus4;
    logic [OFF_W-1:0]         n_minus5;
    logic [5:0]               lim;
    logic [7:0]               sum_a;

    function automatic logic [5:0] min_lim(input logic [OFF_W-1:0] v, input logic [5:0] l);
        logic [5:0] m;
        if (v < OFF_W'(l)) begin
            m = v[5:0];
        end else begin
            m = l;
        end
        return m;
    endfunction

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_comp_mode <= 1'b0;
            r_max_len   <= irfc_pkg::MAX_LEN_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                irfc_pkg::REG_COMP_MODE: r_comp_mode <= i_cfg_wdata[0];
                irfc_pkg::REG_MAX_LEN:   r_max_len   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Decode the position of the incoming byte
    always_comb begin
        in_frame = r_byte_count < CNT_W'(MAX_FRAME);
        off_w    = OFF_W'(r_byte_count) - OFF_W'(3);
        half_w   = off_w >> 1;
        if (r_comp_mode) begin
            fits     = r_byte_count[0] && (half_w < OFF_W'(irfc_pkg::STORE_DEPTH));
            st_waddr = half_w[irfc_pkg::STORE_AW-1:0];
        end else begin
            fits     = off_w < OFF_W'(irfc_pkg::STORE_DEPTH);
            st_waddr = off_w[irfc_pkg::STORE_AW-1:0];
        end
        st_we = i_cmd.take_byte && in_frame && (r_byte_count >= CNT_W'(3)) && fits;
    end

    // Absorb a byte, or clear the frame after the check
    always_comb begin
        n_byte_count = r_byte_count;
        n_header_bad = r_header_bad;
        n_pair_bad   = r_pair_bad;
        n_sum        = r_sum;
        n_prev       = r_prev;
        n_newest     = r_newest;
        n_byte_four  = r_byte_four;
        n_byte_three = r_byte_three;
        if (i_cmd.do_check) begin
            n_byte_count = '0;
            n_header_bad = 1'b0;
            n_pair_bad   = 1'b0;
            n_sum        = '0;
            n_prev       = '0;
            n_newest     = '0;
            n_byte_four  = '0;
        end else if (i_cmd.take_byte && in_frame) begin
            if (r_byte_count < CNT_W'(3)) begin
                if (i_rx_byte != irfc_pkg::hdr_byte(r_byte_count[1:0])) begin
                    n_header_bad = 1'b1;
                end
            end else if (r_comp_mode) begin
                if (r_byte_count[0]) begin
                    n_sum = r_sum + i_rx_byte;
                end else if (i_rx_byte != ~r_newest) begin
                    n_pair_bad = 1'b1;
                end
            end else begin
                n_sum = r_sum + i_rx_byte;
                if (r_byte_count == CNT_W'(4)) begin
                    n_byte_four = i_rx_byte;
                end
            end
            if (r_byte_count == CNT_W'(3)) begin
                n_byte_three = i_rx_byte;
            end
            n_prev       = r_newest;
            n_newest     = i_rx_byte;
            n_byte_count = r_byte_count + CNT_W'(1);
        end
    end

    // Evaluate the reply against the layouts
    always_comb begin
        n_w      = OFF_W'(r_byte_count);
        n_minus4 = n_w - OFF_W'(4);
        n_minus5 = n_w - OFF_W'(5);
        lim      = (r_max_len < 6'(MAX_PAYLOAD)) ? r_max_len : 6'(MAX_PAYLOAD);
        sum_a    = r_sum - r_newest;
        n_stat   = irfc_pkg::STAT_BAD;
        n_cnt    = '0;
        n_layout = 1'b0;
        if (n_w == '0) begin
            n_stat = irfc_pkg::STAT_EMPTY;
        end else if (r_comp_mode) begin
            if ((n_w >= OFF_W'(5)) && n_w[0] && !r_header_bad && !r_pair_bad &&
                (r_prev == 8'(r_sum - r_prev))) begin
                n_stat = irfc_pkg::STAT_OK;
                n_cnt  = min_lim(n_minus5 >> 1, lim);
            end
        end else if ((n_w >= OFF_W'(4)) && !r_header_bad) begin
            if (r_newest == sum_a) begin
                n_stat = irfc_pkg::STAT_OK;
                n_cnt  = min_lim(n_minus4, lim);
            end else if ((n_w >= OFF_W'(5)) && (r_prev == 8'(sum_a - r_prev))) begin
                n_stat = irfc_pkg::STAT_OK;
                n_cnt  = min_lim(n_minus5, lim);
            end else if ((n_w >= OFF_W'(6)) && (r_byte_three == ~r_byte_four) &&
                         (r_newest == 8'(sum_a - r_byte_four))) begin
                n_stat   = irfc_pkg::STAT_OK;
                n_cnt    = min_lim(n_minus5, lim);
                n_layout = 1'b1;
            end
        end
    end

    // Frame registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
            r_header_bad <= 1'b0;
            r_pair_bad   <= 1'b0;
            r_sum        <= '0;
            r_prev       <= '0;
            r_newest     <= '0;
            r_byte_four  <= '0;
            r_byte_three <= '0;
        end else begin
            r_byte_count <= n_byte_count;
            r_header_bad <= n_header_bad;
            r_pair_bad   <= n_pair_bad;
            r_sum        <= n_sum;
            r_prev       <= n_prev;
            r_newest     <= n_newest;
            r_byte_four  <= n_byte_four;
            r_byte_three <= n_byte_three;
        end
    end

    // Hold the check result; step the emission index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stat   <= irfc_pkg::STAT_OK;
            r_cnt    <= '0;
            r_layout <= 1'b0;
            r_k      <= '0;
        end else if (i_cmd.do_check) begin
            r_stat   <= n_stat;
            r_cnt    <= n_cnt;
            r_layout <= n_layout;
            r_k      <= '0;
        end else if (i_cmd.advance) begin
            r_k      <= r_k + 6'd1;
        end
    end

    // Skip the opcode complement when the third layout matched
    assign st_raddr = (r_layout && (r_k != '0)) ? (r_k + 6'd1) : r_k;

    irfc_ram #(
        .WIDTH (8),
        .DEPTH (irfc_pkg::STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (i_rx_byte),
        .i_re    (i_cmd.read_req),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    assign o_sts.emit_done = (r_k == r_cnt);

    // Output fields
    assign o_payload_byte   = i_cmd.show_status ? 8'h00 : st_rdata;
    assign o_is_status      = i_cmd.show_status;
    assign o_last           = i_cmd.show_status;
    assign o_status         = i_cmd.show_status ? r_stat : irfc_pkg::STAT_OK;
    assign o_payload_length = i_cmd.show_status ? r_cnt : 6'd0;

endmodule

// ===== src/irfc_ctrl.sv =====
// Controller: sequences byte intake, reply check and result emission.
module irfc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                i_byte_valid,
    input  logic                i_end_of_message,
    output logic                o_ready,
    output logic                o_valid,
    input  logic                i_ready,
    input  irfc_pkg::t_dp_sts   i_sts,
    output irfc_pkg::t_dp_cmd   o_cmd
);

    irfc_pkg::t_state r_state, n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= irfc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            irfc_pkg::S_IDLE: begin
                if (i_valid && i_end_of_message) begin
                    n_state = irfc_pkg::S_CHECK;
                end
            end
            irfc_pkg::S_CHECK: n_state = irfc_pkg::S_READ;
            irfc_pkg::S_READ: begin
                n_state = i_sts.emit_done ? irfc_pkg::S_STATUS : irfc_pkg::S_SHOW;
            end
            irfc_pkg::S_SHOW: begin
                if (i_ready) begin
                    n_state = irfc_pkg::S_READ;
                end
            end
            irfc_pkg::S_STATUS: begin
                if (i_ready) begin
                    n_state = irfc_pkg::S_IDLE;
                end
            end
            default: n_state = irfc_pkg::S_IDLE;
        endcase
    end

    // Outputs and datapath commands
    always_comb begin
        o_ready           = 1'b0;
        o_valid           = 1'b0;
        o_cmd             = '0;
        case (r_state)
            irfc_pkg::S_IDLE: begin
                o_ready         = 1'b1;
                o_cmd.take_byte = i_valid && i_byte_valid;
            end
            irfc_pkg::S_CHECK: o_cmd.do_check = 1'b1;
            irfc_pkg::S_READ:  o_cmd.read_req = !i_sts.emit_done;
            irfc_pkg::S_SHOW: begin
                o_valid       = 1'b1;
                o_cmd.advance = i_ready;
            end
            irfc_pkg::S_STATUS: begin
                o_valid           = 1'b1;
                o_cmd.show_status = 1'b1;
            end
            default: ;
        endcase
    end

endmodule

// ===== src/ir_reply_frame_checker.sv =====
// Sequence: a byte-only input transfer is absorbed while idle, and the next one is taken at once.
// An end transfer moves the controller to checking, then each payload byte takes a store read
// and then an output, and the status item follows last; an output stall holds the sequence.
// The controller alternates a store read and an output, so it reads no further payload byte
// until the current one has been taken, and it takes no input until the status item is taken.
// Reset (synchronous, active low) clears the controller, frame state and registers
// (complement mode off, payload limit 32); the payload store is not cleared.
module ir_reply_frame_checker #(
    parameter int MAX_PAYLOAD = irfc_pkg::DEF_MAX_PAYLOAD,
    parameter int MAX_FRAME   = irfc_pkg::DEF_MAX_FRAME
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [0:0]  i_cfg_index,
    input  logic [5:0]  i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_byte_valid,
    input  logic        i_end_of_message,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_payload_byte,
    output logic        o_is_status,
    output logic [1:0]  o_status,
    output logic [5:0]  o_payload_length,
    output logic        o_last
);

    irfc_pkg::t_dp_cmd cmd;
    irfc_pkg::t_dp_sts sts;

    irfc_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .i_byte_valid     (i_byte_valid),
        .i_end_of_message (i_end_of_message),
        .o_ready          (o_ready),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .i_sts            (sts),
        .o_cmd            (cmd)
    );

    irfc_dp #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .MAX_FRAME   (MAX_FRAME)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_rx_byte        (i_rx_byte),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .o_payload_byte   (o_payload_byte),
        .o_is_status      (o_is_status),
        .o_status         (o_status),
        .o_payload_length (o_payload_length),
        .o_last           (o_last)
    );

endmodule
